FILE: rtl/mbap_pkg.sv
package mbap_pkg;

  localparam int PDU_LIMIT_DEF      = 253;
  localparam int MIN_RTU_LENGTH_DEF = 4;
  localparam int HDR_BYTES          = 6;

  typedef enum logic [1:0] {
    FN_START   = 2'd0,
    FN_TX      = 2'd1,
    FN_RX      = 2'd2,
    FN_TIMEOUT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_TX     = 2'd1,
    KIND_RX     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOCFG   = 3'd1,
    ST_LEN     = 3'd2,
    ST_FRAME   = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_EXC     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1
  } rx_phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic [8:0] frame_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last;
    logic [2:0] status;
  } out_t;

  // One transaction's worth of results: a single result or a six-byte header.
  typedef struct packed {
    logic        hdr;
    logic [15:0] tid;
    logic [8:0]  len;
    out_t        res;
  } set_t;

  typedef struct packed {
    logic busy;
    logic hdr_active;
  } emit_stat_t;

endpackage

FILE: rtl/mbap_core.sv
module mbap_core import mbap_pkg::*; #(
  parameter int PDU_LIMIT      = PDU_LIMIT_DEF,
  parameter int MIN_RTU_LENGTH = MIN_RTU_LENGTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  in_t  in_item,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output logic set_load,
  output set_t set_new
);

  localparam logic [8:0]  FLEN_MIN   = 9'(MIN_RTU_LENGTH);
  localparam logic [9:0]  FLEN_MAX   = 10'(PDU_LIMIT + 3);
  localparam logic [15:0] RX_LEN_MAX = 16'(PDU_LIMIT + 1);
  localparam logic [8:0]  HDR_CNT    = 9'(HDR_BYTES);

  logic        link_open_r, link_open_nxt;
  logic [15:0] tid_r, tid_nxt;
  logic [8:0]  tx_rem_r, tx_rem_nxt;
  logic [47:0] rx_hdr_r, rx_hdr_nxt;
  rx_phase_t   rx_phase_r, rx_phase_nxt;
  logic [8:0]  rx_cnt_r, rx_cnt_nxt;
  logic        rx_exc_r, rx_exc_nxt;

  logic [47:0] hdr_shift;
  logic [8:0]  cnt_inc;
  logic        exc_now;
  logic        flen_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_open_r <= 1'b0;
      tid_r       <= '0;
      tx_rem_r    <= '0;
      rx_hdr_r    <= '0;
      rx_phase_r  <= PH_HUNT;
      rx_cnt_r    <= '0;
      rx_exc_r    <= 1'b0;
    end else begin
      link_open_r <= link_open_nxt;
      tid_r       <= tid_nxt;
      tx_rem_r    <= tx_rem_nxt;
      rx_hdr_r    <= rx_hdr_nxt;
      rx_phase_r  <= rx_phase_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      rx_exc_r    <= rx_exc_nxt;
    end
  end

  assign hdr_shift = {rx_hdr_r[39:0], in_item.data_byte};
  assign cnt_inc   = rx_cnt_r + 9'd1;
  assign exc_now   = (rx_cnt_r == 9'd1) ? in_item.data_byte[7] : rx_exc_r;
  assign flen_bad  = (in_item.frame_length < FLEN_MIN) ||
                     ({1'b0, in_item.frame_length} > FLEN_MAX);

  always_comb begin
    link_open_nxt = link_open_r;
    tid_nxt       = tid_r;
    tx_rem_nxt    = tx_rem_r;
    rx_hdr_nxt    = rx_hdr_r;
    rx_phase_nxt  = rx_phase_r;
    rx_cnt_nxt    = rx_cnt_r;
    rx_exc_nxt    = rx_exc_r;
    set_load      = 1'b0;
    set_new       = '0;

    if (fire) begin
      if (!link_open_r) begin
        set_load              = 1'b1;
        set_new.res.status    = ST_NOCFG;
      end else begin
        case (func_t'(in_item.func))
          FN_START: begin
            set_load = 1'b1;
            if (flen_bad) begin
              set_new.res.status = ST_LEN;
            end else begin
              tid_nxt     = tid_r + 16'd1;
              tx_rem_nxt  = in_item.frame_length;
              set_new.hdr = 1'b1;
              set_new.tid = tid_r + 16'd1;
              set_new.len = in_item.frame_length - 9'd2;
            end
          end
          FN_TX: begin
            if (tx_rem_r != 9'd0) begin
              tx_rem_nxt = tx_rem_r - 9'd1;
              if (tx_rem_r > 9'd2) begin
                set_load             = 1'b1;
                set_new.res.out_byte = in_item.data_byte;
                set_new.res.out_kind = KIND_TX;
              end
            end
          end
          FN_RX: begin
            if (rx_phase_r != PH_PAYLOAD) begin
              if (cnt_inc < HDR_CNT) begin
                rx_hdr_nxt = hdr_shift;
                rx_cnt_nxt = cnt_inc;
              end else if ((hdr_shift[31:16] != 16'd0) || (hdr_shift[47:32] != tid_r) ||
                           (hdr_shift[15:0] == 16'd0) || (hdr_shift[15:0] > RX_LEN_MAX)) begin
                rx_hdr_nxt         = '0;
                rx_phase_nxt       = PH_HUNT;
                rx_cnt_nxt         = '0;
                rx_exc_nxt         = 1'b0;
                set_load           = 1'b1;
                set_new.res.status = ST_FRAME;
              end else begin
                rx_hdr_nxt   = hdr_shift;
                rx_phase_nxt = PH_PAYLOAD;
                rx_cnt_nxt   = '0;
                rx_exc_nxt   = 1'b0;
              end
            end else begin
              set_load             = 1'b1;
              set_new.res.out_byte = in_item.data_byte;
              set_new.res.out_kind = KIND_RX;
              rx_exc_nxt           = exc_now;
              rx_cnt_nxt           = cnt_inc;
              if ({7'd0, cnt_inc} >= rx_hdr_r[15:0]) begin
                rx_hdr_nxt         = '0;
                rx_phase_nxt       = PH_HUNT;
                rx_cnt_nxt         = '0;
                rx_exc_nxt         = 1'b0;
                set_new.res.last   = 1'b1;
                set_new.res.status = exc_now ? ST_EXC : ST_OK;
              end
            end
          end
          default: begin
            rx_hdr_nxt         = '0;
            rx_phase_nxt       = PH_HUNT;
            rx_cnt_nxt         = '0;
            rx_exc_nxt         = 1'b0;
            set_load           = 1'b1;
            set_new.res.status = ST_TIMEOUT;
          end
        endcase
      end
    end

    if (cfg_wr_en) begin
      link_open_nxt = cfg_wr_data;
      tx_rem_nxt    = '0;
      rx_hdr_nxt    = '0;
      rx_phase_nxt  = PH_HUNT;
      rx_cnt_nxt    = '0;
      rx_exc_nxt    = 1'b0;
      if (cfg_wr_data) begin
        tid_nxt = '0;
      end
    end
  end

endmodule

FILE: rtl/mbap_emit.sv
module mbap_emit import mbap_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       set_load,
  input  set_t       set_new,
  output logic       ready,
  output emit_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  localparam logic [2:0] IDX_LAST = 3'(HDR_BYTES - 1);

  logic       set_valid_r, set_valid_nxt;
  set_t       set_r, set_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_r, out_nxt;

  logic out_take, out_free, drain, set_final;
  out_t cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      set_valid_r <= set_valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    set_r <= set_nxt;
    out_r <= out_nxt;
  end

  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || out_take;
  assign drain     = set_valid_r && out_free;
  assign set_final = !set_r.hdr || (idx_r == IDX_LAST);
  assign ready     = !set_valid_r || (drain && set_final);

  always_comb begin
    cur          = set_r.res;
    if (set_r.hdr) begin
      cur.out_kind = KIND_TX;
      cur.status   = ST_OK;
      cur.last     = 1'b0;
      case (idx_r)
        3'd0: cur.out_byte = set_r.tid[15:8];
        3'd1: cur.out_byte = set_r.tid[7:0];
        3'd4: cur.out_byte = {7'd0, set_r.len[8]};
        3'd5: begin
          cur.out_byte = set_r.len[7:0];
          cur.last     = 1'b1;
        end
        default: cur.out_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    set_valid_nxt = set_valid_r;
    set_nxt       = set_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (drain) begin
      out_valid_nxt = 1'b1;
      out_nxt       = cur;
      if (set_final) begin
        set_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    if (set_load) begin
      set_valid_nxt = 1'b1;
      set_nxt       = set_new;
      idx_nxt       = '0;
    end
  end

  assign stat.busy       = set_valid_r;
  assign stat.hdr_active = set_valid_r && set_r.hdr;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

FILE: rtl/mbap_framer_deframer.sv
// Channel   Ports                          Payload
// input     in_valid, in_stall, in_data    in_t: func, data_byte, frame_length
// result    out_valid, out_stall, out_data out_t: out_byte, out_kind, last, status
// config    cfg_wr_en, cfg_wr_data         link_open
//
// One input transaction per cycle unless stalled; results go via set and output registers.
// A valid start request yields a six-byte header, one byte per cycle from the result set
// register while out_stall is low; the input is stalled until the last header byte drains.
// Synchronous active-low reset clears link_open, the transaction id and all progress.
// A stalled output register still lets one more transaction be accepted.
module mbap_framer_deframer import mbap_pkg::*; #(
  parameter int PDU_LIMIT      = PDU_LIMIT_DEF,
  parameter int MIN_RTU_LENGTH = MIN_RTU_LENGTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data
);

  logic       ready;
  logic       fire;
  logic       set_load;
  set_t       set_new;
  emit_stat_t stat;

  assign in_stall = !ready;
  assign fire     = in_valid && ready;

  mbap_core #(
    .PDU_LIMIT      (PDU_LIMIT),
    .MIN_RTU_LENGTH (MIN_RTU_LENGTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .in_item     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .set_load    (set_load),
    .set_new     (set_new)
  );

  mbap_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_load  (set_load),
    .set_new   (set_new),
    .ready     (ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stat.busy)
    else $error("input stalled with empty result set");

  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_kind == KIND_STATUS) |->
      (out_data.out_byte == 8'h00 && !out_data.last && out_data.status != ST_OK))
    else $error("malformed status-only result");

  a_tx_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_kind == KIND_TX) |-> (out_data.status == ST_OK))
    else $error("transmit byte carries nonzero status");

  a_hdr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.hdr_active && !$past(stat.hdr_active)) |-> in_stall)
    else $error("input accepted during header run");

endmodule
